[hdl/zlhw_pkg.sv]
// Shared types and constants for the ZIP local header walker.
// No dependencies; used by zlhw_front, zlhw_queue, zlhw_back and the top level.
`timescale 1ns / 1ps

package zlhw_pkg;

    // Result kinds
    localparam logic [1:0] KIND_NAME = 2'd0;
    localparam logic [1:0] KIND_REC  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Stop reasons carried on the end result
    localparam logic [1:0] REASON_CLEAN  = 2'd0;
    localparam logic [1:0] REASON_BADSIG = 2'd1;
    localparam logic [1:0] REASON_TRUNC  = 2'd2;

    // Front-to-back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // All results caused by one input byte, in emission order name, record, end
    typedef struct packed {
        logic        has_name;
        logic [7:0]  name_byte;
        logic        has_rec;
        logic [15:0] method;
        logic [31:0] packed_size;
        logic [31:0] plain_size;
        logic [31:0] payload_offset;
        logic [15:0] name_length;
        logic        had_descriptor;
        logic        has_end;
        logic [1:0]  reason;
        logic [15:0] index;
        logic [15:0] end_index;
    } run_t;

endpackage

[hdl/zlhw_front.sv]
// Front end: parses local headers, names, skips and descriptors one byte per request.
// Produces one run_t per request that causes results. Depends on zlhw_pkg.
`timescale 1ns / 1ps

module zlhw_front #(
    parameter int INDEX_BITS  = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [7:0]        in_data_byte,
    input  logic              in_is_last,
    output logic              run_push,
    output zlhw_pkg::run_t    run
);

    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_NAME = 3'd1;
    localparam logic [2:0] PH_SKIP = 3'd2;
    localparam logic [2:0] PH_DESC = 3'd3;
    localparam logic [2:0] PH_STOP = 3'd4;

    localparam logic [3:0][7:0] LOCAL_SIG = {8'h04, 8'h03, 8'h4B, 8'h50};
    localparam logic [31:0]     DESC_SIG  = 32'h0807_4B50;
    localparam logic [4:0]      HDR_LAST  = 5'd29;
    localparam logic [4:0]      DESC_LEN_SIGNED = 5'd16;
    localparam logic [4:0]      DESC_LEN_PLAIN  = 5'd12;
    localparam logic [4:0]      DESC_SIG_LEN    = 5'd4;

    logic [2:0]             phase_reg, phase_next;
    logic [4:0]             fbc_reg, fbc_next;
    logic [63:0]            hf0_reg, hf0_next;
    logic [63:0]            hf1_reg, hf1_next;
    logic [32:0]            skip_reg, skip_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [63:0]            dbuf_reg, dbuf_next;
    logic [4:0]             dcnt_reg, dcnt_next;
    logic                   dsig_reg, dsig_next;
    logic [OFFSET_BITS-1:0] pat_reg, pat_next;
    logic [INDEX_BITS-1:0]  cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [1:0]             stop_reg, stop_next;

    always_comb begin
        logic [4:0]  k;
        logic [1:0]  sub;
        logic [15:0] nlen;
        logic [15:0] xlen;
        logic [32:0] skip_dec;
        logic        do_after;
        logic        rec_now;
        logic        rec_final;
        logic        pend_mid;
        logic        want;
        logic [4:0]  dlen;

        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        hf0_next   = hf0_reg;
        hf1_next   = hf1_reg;
        skip_next  = skip_reg;
        pos_next   = pos_reg + OFFSET_BITS'(1);
        dbuf_next  = dbuf_reg;
        dcnt_next  = dcnt_reg;
        dsig_next  = dsig_reg;
        pat_next   = pat_reg;
        cnt_next   = cnt_reg;
        stop_next  = stop_reg;
        run        = '0;
        k          = fbc_reg;
        sub        = 2'd0;
        nlen       = 16'd0;
        xlen       = 16'd0;
        skip_dec   = skip_reg - 33'd1;
        do_after   = 1'b0;
        rec_now    = 1'b0;
        dlen       = DESC_LEN_PLAIN;

        case (phase_reg)
            PH_HDR: begin
                if (k == 5'd0) begin
                    hf0_next = '0;
                    hf1_next = '0;
                end
                case (k) inside
                    [5'd0:5'd3]: begin
                        if (in_data_byte != LOCAL_SIG[k[1:0]]) begin
                            phase_next = PH_STOP;
                            stop_next  = zlhw_pkg::REASON_BADSIG;
                        end
                    end
                    5'd6, 5'd7: hf0_next[16 + 8 * int'(k[0]) +: 8] = in_data_byte;
                    5'd8, 5'd9: hf0_next[8 * int'(k[0]) +: 8] = in_data_byte;
                    [5'd18:5'd21]: begin
                        sub = 2'(k - 5'd18);
                        hf0_next[32 + 8 * int'(sub) +: 8] = in_data_byte;
                    end
                    [5'd22:5'd25]: begin
                        sub = 2'(k - 5'd22);
                        hf1_next[8 * int'(sub) +: 8] = in_data_byte;
                    end
                    [5'd26:5'd29]: begin
                        sub = 2'(k - 5'd26);
                        hf1_next[32 + 8 * int'(sub) +: 8] = in_data_byte;
                    end
                    default: ;
                endcase
                if (phase_next == PH_HDR) begin
                    if (k == HDR_LAST) begin
                        nlen     = hf1_next[47:32];
                        xlen     = hf1_next[63:48];
                        fbc_next = 5'd0;
                        pat_next = pos_reg + OFFSET_BITS'(1) + OFFSET_BITS'(nlen)
                                   + OFFSET_BITS'(xlen);
                        if (nlen != 16'd0) begin
                            skip_next  = 33'(nlen);
                            phase_next = PH_NAME;
                        end else begin
                            do_after = 1'b1;
                        end
                    end else begin
                        fbc_next = k + 5'd1;
                    end
                end
            end
            PH_NAME: begin
                run.has_name  = 1'b1;
                run.name_byte = in_data_byte;
                skip_next     = skip_dec;
                if (skip_dec == 33'd0) begin
                    do_after = 1'b1;
                end
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 33'd0) begin
                    phase_next = hf0_reg[19] ? PH_DESC : PH_HDR;
                end
            end
            PH_DESC: begin
                dbuf_next = {in_data_byte, dbuf_reg[63:8]};
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_next == DESC_SIG_LEN) begin
                    dsig_next = (dbuf_next[63:32] == DESC_SIG);
                end
                dlen = dsig_next ? DESC_LEN_SIGNED : DESC_LEN_PLAIN;
                if (dcnt_next >= dlen) begin
                    hf0_next   = {dbuf_next[31:0], hf0_reg[31:0]};
                    hf1_next   = {hf1_reg[63:32], dbuf_next[63:32]};
                    rec_now    = 1'b1;
                    dcnt_next  = 5'd0;
                    phase_next = PH_HDR;
                end
            end
            default: ;
        endcase

        // Name done: set up the skip and maybe close the entry now
        want = hf0_next[19];
        if (do_after) begin
            skip_next = 33'(hf1_next[63:48]) + 33'(hf0_next[63:32]);
            dbuf_next = '0;
            dcnt_next = 5'd0;
            dsig_next = 1'b0;
            if (!want) begin
                rec_now = 1'b1;
            end
            if (skip_next != 33'd0) begin
                phase_next = PH_SKIP;
            end else begin
                phase_next = want ? PH_DESC : PH_HDR;
            end
        end

        pend_mid  = rec_now ? 1'b0 : (do_after ? 1'b1 : pend_reg);
        rec_final = rec_now || (in_is_last && pend_mid);
        pend_next = rec_final ? 1'b0 : pend_mid;
        if (rec_final) begin
            cnt_next = cnt_reg + INDEX_BITS'(1);
        end

        run.index          = 16'(cnt_reg);
        run.has_rec        = rec_final;
        run.method         = hf0_next[15:0];
        run.packed_size    = hf0_next[63:32];
        run.plain_size     = hf1_next[31:0];
        run.payload_offset = 32'(pat_next);
        run.name_length    = hf1_next[47:32];
        run.had_descriptor = hf0_next[19];
        run.has_end        = in_is_last;
        run.end_index      = 16'(cnt_next);
        if (stop_next != zlhw_pkg::REASON_CLEAN) begin
            run.reason = stop_next;
        end else if ((phase_next == PH_HDR && fbc_next != 5'd0) || phase_next == PH_NAME) begin
            run.reason = zlhw_pkg::REASON_TRUNC;
        end else begin
            run.reason = zlhw_pkg::REASON_CLEAN;
        end
        if (!run.has_rec) begin
            run.method         = '0;
            run.packed_size    = '0;
            run.plain_size     = '0;
            run.payload_offset = '0;
            run.name_length    = '0;
            run.had_descriptor = 1'b0;
        end
        if (!run.has_end) begin
            run.reason = zlhw_pkg::REASON_CLEAN;
        end

        run_push = in_fire && (run.has_name || rec_final || in_is_last);

        // End of archive: back to the reset state
        if (in_is_last) begin
            phase_next = PH_HDR;
            fbc_next   = 5'd0;
            hf0_next   = '0;
            hf1_next   = '0;
            skip_next  = '0;
            pos_next   = '0;
            dbuf_next  = '0;
            dcnt_next  = 5'd0;
            dsig_next  = 1'b0;
            pat_next   = '0;
            cnt_next   = '0;
            pend_next  = 1'b0;
            stop_next  = zlhw_pkg::REASON_CLEAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR;
            fbc_reg   <= 5'd0;
            hf0_reg   <= '0;
            hf1_reg   <= '0;
            skip_reg  <= '0;
            pos_reg   <= '0;
            dbuf_reg  <= '0;
            dcnt_reg  <= 5'd0;
            dsig_reg  <= 1'b0;
            pat_reg   <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            stop_reg  <= zlhw_pkg::REASON_CLEAN;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            hf0_reg   <= hf0_next;
            hf1_reg   <= hf1_next;
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
            dbuf_reg  <= dbuf_next;
            dcnt_reg  <= dcnt_next;
            dsig_reg  <= dsig_next;
            pat_reg   <= pat_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

[hdl/zlhw_queue.sv]
// Short run queue between the parser front end and the result back end.
// Holds zlhw_pkg::run_t entries; depends on zlhw_pkg.
`timescale 1ns / 1ps

module zlhw_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  zlhw_pkg::run_t push_run,
    input  logic           pop,
    output logic           head_valid,
    output zlhw_pkg::run_t head_run,
    output logic           full
);

    zlhw_pkg::run_t            mem [zlhw_pkg::Q_DEPTH];
    logic [zlhw_pkg::Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [zlhw_pkg::Q_AW:0]   count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (zlhw_pkg::Q_AW + 1)'(zlhw_pkg::Q_DEPTH));
    assign head_run   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (zlhw_pkg::Q_AW + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (zlhw_pkg::Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + (zlhw_pkg::Q_AW)'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + (zlhw_pkg::Q_AW)'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[hdl/zlhw_back.sv]
// Back end: unrolls each queued run into name, record and end results.
// Drives the registered result channel. Depends on zlhw_pkg.
`timescale 1ns / 1ps

module zlhw_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  zlhw_pkg::run_t q_run,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_kind,
    output logic [7:0]     m_name_byte,
    output logic [15:0]    m_entry_index,
    output logic [15:0]    m_method,
    output logic [31:0]    m_packed_size,
    output logic [31:0]    m_plain_size,
    output logic [31:0]    m_payload_offset,
    output logic [15:0]    m_name_length,
    output logic           m_had_descriptor,
    output logic [1:0]     m_stop_reason,
    output logic           m_last_of_run
);

    logic        valid_reg, valid_next;
    logic        done_name_reg, done_name_next;
    logic        done_rec_reg, done_rec_next;
    logic [1:0]  kind_reg;
    logic [7:0]  name_byte_reg;
    logic [15:0] index_reg;
    logic [15:0] method_reg;
    logic [31:0] packed_reg;
    logic [31:0] plain_reg;
    logic [31:0] offset_reg;
    logic [15:0] nlen_reg;
    logic        had_desc_reg;
    logic [1:0]  reason_reg;
    logic        last_reg;

    logic        load;
    logic [1:0]  pick;
    logic        pick_last;

    always_comb begin
        load = q_valid && (!valid_reg || m_ready);
        if (q_run.has_name && !done_name_reg) begin
            pick      = zlhw_pkg::KIND_NAME;
            pick_last = !q_run.has_rec && !q_run.has_end;
        end else if (q_run.has_rec && !done_rec_reg) begin
            pick      = zlhw_pkg::KIND_REC;
            pick_last = !q_run.has_end;
        end else begin
            pick      = zlhw_pkg::KIND_END;
            pick_last = 1'b1;
        end
        q_pop = load && pick_last;

        valid_next     = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);
        done_name_next = done_name_reg;
        done_rec_next  = done_rec_reg;
        if (load) begin
            if (pick_last) begin
                done_name_next = 1'b0;
                done_rec_next  = 1'b0;
            end else if (pick == zlhw_pkg::KIND_NAME) begin
                done_name_next = 1'b1;
            end else begin
                done_rec_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            done_name_reg <= 1'b0;
            done_rec_reg  <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            done_name_reg <= done_name_next;
            done_rec_reg  <= done_rec_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg      <= pick;
            last_reg      <= pick_last;
            name_byte_reg <= '0;
            method_reg    <= '0;
            packed_reg    <= '0;
            plain_reg     <= '0;
            offset_reg    <= '0;
            nlen_reg      <= '0;
            had_desc_reg  <= 1'b0;
            reason_reg    <= zlhw_pkg::REASON_CLEAN;
            index_reg     <= q_run.index;
            case (pick)
                zlhw_pkg::KIND_NAME: begin
                    name_byte_reg <= q_run.name_byte;
                end
                zlhw_pkg::KIND_REC: begin
                    method_reg   <= q_run.method;
                    packed_reg   <= q_run.packed_size;
                    plain_reg    <= q_run.plain_size;
                    offset_reg   <= q_run.payload_offset;
                    nlen_reg     <= q_run.name_length;
                    had_desc_reg <= q_run.had_descriptor;
                end
                default: begin
                    index_reg  <= q_run.end_index;
                    reason_reg <= q_run.reason;
                end
            endcase
        end
    end

    assign m_valid          = valid_reg;
    assign m_kind           = kind_reg;
    assign m_name_byte      = name_byte_reg;
    assign m_entry_index    = index_reg;
    assign m_method         = method_reg;
    assign m_packed_size    = packed_reg;
    assign m_plain_size     = plain_reg;
    assign m_payload_offset = offset_reg;
    assign m_name_length    = nlen_reg;
    assign m_had_descriptor = had_desc_reg;
    assign m_stop_reason    = reason_reg;
    assign m_last_of_run    = last_reg;

    a_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && kind_reg == zlhw_pkg::KIND_END |-> last_reg)
        else $error("end result not marked last of run");

    a_reason_only_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && kind_reg != zlhw_pkg::KIND_END |-> reason_reg == zlhw_pkg::REASON_CLEAN)
        else $error("stop reason set on a non-end result");

    a_pop_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_partial_run_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_name_reg || done_rec_reg) |-> q_valid)
        else $error("run partly emitted but queue head gone");

endmodule

[hdl/zip_local_header_walker_unit.sv]
// ZIP local header walker, top level: front parser, run queue, result back end.
// A byte's results go into the run queue and from there into the registered output.
// Throughput: one byte per cycle; each result is a separate output transfer, so a byte
// that causes two or three results holds the output for each of them in turn; the
// four-entry run queue absorbs this and s_ready drops only while it is full.
// Reset: synchronous active-low aresetn clears parser state, queue and output valid.
`timescale 1ns / 1ps

module zip_local_header_walker_unit #(
    parameter int INDEX_BITS  = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_name_byte,
    output logic [15:0] m_entry_index,
    output logic [15:0] m_method,
    output logic [31:0] m_packed_size,
    output logic [31:0] m_plain_size,
    output logic [31:0] m_payload_offset,
    output logic [15:0] m_name_length,
    output logic        m_had_descriptor,
    output logic [1:0]  m_stop_reason,
    output logic        m_last_of_run
);

    logic           in_fire;
    logic           run_push;
    zlhw_pkg::run_t run;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    zlhw_pkg::run_t q_run;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    zlhw_front #(
        .INDEX_BITS  (INDEX_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .in_data_byte (s_data_byte),
        .in_is_last   (s_is_last),
        .run_push     (run_push),
        .run          (run)
    );

    zlhw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (run_push),
        .push_run   (run),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_run   (q_run),
        .full       (q_full)
    );

    zlhw_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_run            (q_run),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_name_byte      (m_name_byte),
        .m_entry_index    (m_entry_index),
        .m_method         (m_method),
        .m_packed_size    (m_packed_size),
        .m_plain_size     (m_plain_size),
        .m_payload_offset (m_payload_offset),
        .m_name_length    (m_name_length),
        .m_had_descriptor (m_had_descriptor),
        .m_stop_reason    (m_stop_reason),
        .m_last_of_run    (m_last_of_run)
    );

endmodule
